[hdl/trinucleotide_entropy_score_core_macros.svh]
// Assertion macros shared by the trinucleotide entropy score RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef TRINUCLEOTIDE_ENTROPY_SCORE_CORE_MACROS_SVH
`define TRINUCLEOTIDE_ENTROPY_SCORE_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define TES_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication check failed");

// Next-cycle implication, disabled during reset
`define TES_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication check failed");

`endif

[hdl/tes_pkg.sv]
// Package for the trinucleotide entropy score core: constants, types, bin function.
// No dependencies; imported by every module of the block.
package tes_pkg;

    localparam int NUM_BINS          = 128;
    localparam int BIN_W             = 7;
    localparam int BASE_W            = 3;
    localparam logic [BASE_W-1:0] BASE_OTHER = 3'd4;
    localparam int FRAC_W            = 16;   // log2 fraction bits
    localparam int MANT_W            = 31;   // Q30 mantissa in [1,2)
    localparam int SCALE             = 25600;
    localparam int SCALE_W           = 15;
    localparam int SCORE_W           = 15;
    localparam logic [SCORE_W-1:0] SCORE_MAX = 15'h7FFF;
    localparam int THR_W             = 7;
    localparam logic [THR_W-1:0] THR_RESET = 7'd50;
    localparam int MIN_SCORED_BASES  = 4;
    localparam int DEF_MAX_READ_LEN  = 256;
    localparam int DEF_NORM_CAP      = 64;

    // Status of a multi-cycle arithmetic unit
    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

    // Histogram bin of a trinucleotide: b0*25 + b1*5 + b2
    function automatic logic [BIN_W-1:0] bin_index(
        input logic [BASE_W-1:0] b0,
        input logic [BASE_W-1:0] b1,
        input logic [BASE_W-1:0] b2
    );
        logic [BIN_W-1:0] r;
        r = BIN_W'(b0) * BIN_W'(25) + BIN_W'(b1) * BIN_W'(5) + BIN_W'(b2);
        return r;
    endfunction

endpackage

[hdl/tes_hist_mem.sv]
// Trinucleotide histogram storage: one write port, one registered read port.
// Depends on tes_pkg.
module tes_hist_mem
    import tes_pkg::*;
#(
    parameter int DATA_W = 9
)
(
    input  logic              clk,
    input  logic              rd_en,
    input  logic [BIN_W-1:0]  rd_addr,
    output logic [DATA_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [BIN_W-1:0]  wr_addr,
    input  logic [DATA_W-1:0] wr_data
);

    logic [DATA_W-1:0] mem [NUM_BINS];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[hdl/tes_log2.sv]
// Iterative log2 in Q16: top bit index plus 16 fraction bits by repeated squaring.
// Depends on tes_pkg.
module tes_log2
    import tes_pkg::*;
#(
    parameter int CNT_W = 9,
    parameter int E_W   = 4
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [CNT_W-1:0]        x,
    output unit_stat_t              stat,
    output logic [E_W+FRAC_W-1:0]   result
);

    localparam int IT_W = $clog2(FRAC_W);

    typedef enum logic [2:0] {
        L_IDLE = 3'b001,
        L_SQ   = 3'b010,
        L_NRM  = 3'b100
    } log_state_t;

    log_state_t               state_reg, state_next;
    logic [MANT_W-1:0]        y_reg, y_next;
    logic [2*MANT_W-1:0]      prod_reg;
    logic [FRAC_W-1:0]        frac_reg, frac_next;
    logic [E_W-1:0]           e_reg, e_next;
    logic [IT_W-1:0]          iter_reg, iter_next;
    logic                     done_reg, done_next;

    logic [E_W-1:0]           msb;
    logic [CNT_W+MANT_W-2:0]  x_ext;
    logic [CNT_W+MANT_W-2:0]  x_sh;
    logic [MANT_W:0]          p;

    // Index of the top set bit
    always_comb
    begin
        msb = '0;
        for (int i = 0; i < CNT_W; i++)
        begin
            if (x[i])
            begin
                msb = E_W'(i);
            end
        end
    end

    // Mantissa x / 2^e in Q30
    assign x_ext = {x, (MANT_W-1)'(0)};
    assign x_sh  = x_ext >> msb;
    assign p     = prod_reg[2*MANT_W-1:MANT_W-1];

    always_comb
    begin
        state_next = state_reg;
        y_next     = y_reg;
        frac_next  = frac_reg;
        e_next     = e_reg;
        iter_next  = iter_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            L_IDLE:
            begin
                if (start)
                begin
                    e_next     = msb;
                    y_next     = x_sh[MANT_W-1:0];
                    frac_next  = '0;
                    iter_next  = '0;
                    state_next = L_SQ;
                end
            end
            L_SQ:
            begin
                state_next = L_NRM;
            end
            L_NRM:
            begin
                // one fraction bit per squaring
                if (p[MANT_W])
                begin
                    y_next    = p[MANT_W:1];
                    frac_next = {frac_reg[FRAC_W-2:0], 1'b1};
                end
                else
                begin
                    y_next    = p[MANT_W-1:0];
                    frac_next = {frac_reg[FRAC_W-2:0], 1'b0};
                end
                if (iter_reg == IT_W'(FRAC_W-1))
                begin
                    done_next  = 1'b1;
                    state_next = L_IDLE;
                end
                else
                begin
                    iter_next  = iter_reg + IT_W'(1);
                    state_next = L_SQ;
                end
            end
            default:
            begin
                state_next = L_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        y_reg    <= y_next;
        frac_reg <= frac_next;
        e_reg    <= e_next;
        iter_reg <= iter_next;
        prod_reg <= y_reg * y_reg;
    end

    assign stat.busy = (state_reg != L_IDLE);
    assign stat.done = done_reg;
    assign result    = {e_reg, frac_reg};

endmodule

[hdl/tes_div.sv]
// Restoring divider, one quotient bit per cycle.
// Depends on tes_pkg.
module tes_div
    import tes_pkg::*;
#(
    parameter int NUM_W = 51,
    parameter int DEN_W = 29
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output unit_stat_t       stat,
    output logic [NUM_W-1:0] quo
);

    localparam int C_W = $clog2(NUM_W + 1);

    typedef enum logic [1:0] {
        D_IDLE = 2'b01,
        D_RUN  = 2'b10
    } div_state_t;

    div_state_t        state_reg, state_next;
    logic [NUM_W-1:0]  qn_reg, qn_next;
    logic [DEN_W:0]    rem_reg, rem_next;
    logic [DEN_W-1:0]  den_reg, den_next;
    logic [C_W-1:0]    cnt_reg, cnt_next;
    logic              done_reg, done_next;

    logic [DEN_W:0]    rem_sh;
    logic              ge;

    // Shift in the next numerator bit, subtract if it fits
    assign rem_sh = {rem_reg[DEN_W-1:0], qn_reg[NUM_W-1]};
    assign ge     = (rem_sh >= {1'b0, den_reg});

    always_comb
    begin
        state_next = state_reg;
        qn_next    = qn_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            D_IDLE:
            begin
                if (start)
                begin
                    qn_next    = num;
                    den_next   = den;
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = D_RUN;
                end
            end
            D_RUN:
            begin
                rem_next = ge ? (rem_sh - {1'b0, den_reg}) : rem_sh;
                qn_next  = {qn_reg[NUM_W-2:0], ge};
                if (cnt_reg == C_W'(NUM_W-1))
                begin
                    done_next  = 1'b1;
                    state_next = D_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + C_W'(1);
                end
            end
            default:
            begin
                state_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        qn_reg  <= qn_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        cnt_reg <= cnt_next;
    end

    assign stat.busy = (state_reg != D_IDLE);
    assign stat.done = done_reg;
    assign quo       = qn_reg;

endmodule

[hdl/trinucleotide_entropy_score_core.sv]
// Bases: the first two of a read and those past MAX_READ_LEN are taken directly, others by RMW.
// End of read: sweep of 128 bins, clearing each and passing every filled bin through the
// iterative log2 unit, then, for reads of at least MIN_SCORED_BASES, two more logs and the
// divider before the result transaction is offered.
// Reset: clearing sweep of all 128 bins of the histogram memory, in_stall high meanwhile.
// Threshold resets to 50.
`include "trinucleotide_entropy_score_core_macros.svh"
module trinucleotide_entropy_score_core
    import tes_pkg::*;
#(
    parameter int MAX_READ_LEN = DEF_MAX_READ_LEN,
    parameter int NORM_CAP     = DEF_NORM_CAP
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [THR_W-1:0]   cfg_wdata,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [BASE_W-1:0]  base,
    input  logic               last_base,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [SCORE_W-1:0] score,
    output logic               passes
);

    localparam int CNT_W  = $clog2(MAX_READ_LEN + 1);
    localparam int E_W    = $clog2(CNT_W);
    localparam int LOG_W  = E_W + FRAC_W;
    localparam int PROD_W = CNT_W + LOG_W;
    localparam int SUM_W  = PROD_W + BIN_W;
    localparam int NUM_W  = SUM_W + SCALE_W;

    typedef enum logic [13:0] {
        S_CLR  = 14'b00000000000001,
        S_IDLE = 14'b00000000000010,
        S_UPD  = 14'b00000000000100,
        S_WRD  = 14'b00000000001000,
        S_WCHK = 14'b00000000010000,
        S_WLOG = 14'b00000000100000,
        S_WACC = 14'b00000001000000,
        S_LLS  = 14'b00000010000000,
        S_LL   = 14'b00000100000000,
        S_LKS  = 14'b00001000000000,
        S_LK   = 14'b00010000000000,
        S_NUM  = 14'b00100000000000,
        S_DIV  = 14'b01000000000000,
        S_DONE = 14'b10000000000000
    } core_state_t;

    core_state_t         state_reg, state_next;
    logic [THR_W-1:0]    thr_reg;
    logic [CNT_W-1:0]    bases_seen_reg, bases_seen_next;
    logic [5:0]          prev_reg, prev_next;
    logic [BIN_W-1:0]    bin_reg, bin_next;
    logic                last_reg, last_next;
    logic [BIN_W-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [PROD_W-1:0]   total_reg, total_next;
    logic [PROD_W-1:0]   den_reg, den_next;
    logic [SUM_W-1:0]    t_reg, t_next;
    logic [SCORE_W-1:0]  res_reg, res_next;
    logic                out_valid_reg, out_valid_next;
    logic [SCORE_W-1:0]  score_reg, score_next;
    logic                passes_reg, passes_next;

    logic                acc;
    logic [BASE_W-1:0]   b_cl;
    logic                counting;
    logic                hist_upd;
    logic [BIN_W-1:0]    bin_now;
    logic [CNT_W-1:0]    l_val;
    logic [CNT_W-1:0]    k_val;
    logic                walk_last;
    logic                scored;

    logic                rd_en;
    logic [BIN_W-1:0]    rd_addr;
    logic [CNT_W-1:0]    rd_data;
    logic                wr_en;
    logic [BIN_W-1:0]    wr_addr;
    logic [CNT_W-1:0]    wr_data;

    logic                log_start;
    logic [CNT_W-1:0]    log_x;
    unit_stat_t          log_stat;
    logic [LOG_W-1:0]    log_result;

    logic                div_start;
    logic [NUM_W-1:0]    div_num;
    unit_stat_t          div_stat;
    logic [NUM_W-1:0]    div_quo;

    // Input side decode
    assign in_stall  = (state_reg != S_IDLE);
    assign acc       = in_valid && (state_reg == S_IDLE);
    assign b_cl      = (base > BASE_OTHER) ? BASE_OTHER : base;
    assign counting  = (32'(bases_seen_reg) < MAX_READ_LEN);
    assign hist_upd  = counting && (32'(bases_seen_reg) >= 32'd2);
    assign bin_now   = bin_index(prev_reg[5:3], prev_reg[2:0], b_cl);
    assign l_val     = bases_seen_reg - CNT_W'(2);
    assign k_val     = (32'(l_val) < NORM_CAP) ? l_val : CNT_W'(NORM_CAP);
    assign walk_last = (idx_reg == BIN_W'(NUM_BINS-1));
    assign scored    = (32'(bases_seen_reg) >= MIN_SCORED_BASES);

    // Memory port steering
    assign rd_en   = (acc && hist_upd) || (state_reg == S_WRD);
    assign rd_addr = (state_reg == S_WRD) ? idx_reg : bin_now;
    assign wr_en   = (state_reg == S_UPD) || (state_reg == S_WCHK) || (state_reg == S_CLR);
    assign wr_addr = (state_reg == S_UPD) ? bin_reg : idx_reg;
    assign wr_data = (state_reg == S_UPD) ? (rd_data + CNT_W'(1)) : '0;

    // Log unit operand select
    assign log_start = ((state_reg == S_WCHK) && (rd_data != '0))
                       || (state_reg == S_LLS) || (state_reg == S_LKS);
    assign log_x     = (state_reg == S_WCHK) ? rd_data :
                       (state_reg == S_LLS)  ? l_val : k_val;

    // Divider launch; product is registered inside the divider
    assign div_start = (state_reg == S_NUM) && (den_reg != '0);
    assign div_num   = NUM_W'(t_reg) * NUM_W'(SCALE);

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        bases_seen_next = bases_seen_reg;
        prev_next       = prev_reg;
        bin_next        = bin_reg;
        last_next       = last_reg;
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        prod_next       = prod_reg;
        sum_next        = sum_reg;
        total_next      = total_reg;
        den_next        = den_reg;
        t_next          = t_reg;
        res_next        = res_reg;
        out_valid_next  = out_valid_reg && out_stall;
        score_next      = score_reg;
        passes_next     = passes_reg;
        unique case (state_reg)
            S_CLR:
            begin
                idx_next = idx_reg + BIN_W'(1);
                if (walk_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (acc)
                begin
                    if (counting)
                    begin
                        prev_next       = {prev_reg[2:0], b_cl};
                        bases_seen_next = bases_seen_reg + CNT_W'(1);
                    end
                    bin_next  = bin_now;
                    last_next = last_base;
                    if (hist_upd)
                    begin
                        state_next = S_UPD;
                    end
                    else if (last_base)
                    begin
                        idx_next   = '0;
                        sum_next   = '0;
                        state_next = S_WRD;
                    end
                end
            end
            S_UPD:
            begin
                if (last_reg)
                begin
                    idx_next   = '0;
                    sum_next   = '0;
                    state_next = S_WRD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_WRD:
            begin
                state_next = S_WCHK;
            end
            S_WCHK:
            begin
                // bin is cleared as it is read
                cnt_next = rd_data;
                if (rd_data != '0)
                begin
                    state_next = S_WLOG;
                end
                else if (walk_last)
                begin
                    res_next   = '0;
                    state_next = scored ? S_LLS : S_DONE;
                end
                else
                begin
                    idx_next   = idx_reg + BIN_W'(1);
                    state_next = S_WRD;
                end
            end
            S_WLOG:
            begin
                if (log_stat.done)
                begin
                    prod_next  = PROD_W'(cnt_reg) * PROD_W'(log_result);
                    state_next = S_WACC;
                end
            end
            S_WACC:
            begin
                sum_next = sum_reg + SUM_W'(prod_reg);
                if (walk_last)
                begin
                    res_next   = '0;
                    state_next = scored ? S_LLS : S_DONE;
                end
                else
                begin
                    idx_next   = idx_reg + BIN_W'(1);
                    state_next = S_WRD;
                end
            end
            S_LLS:
            begin
                state_next = S_LL;
            end
            S_LL:
            begin
                if (log_stat.done)
                begin
                    total_next = PROD_W'(l_val) * PROD_W'(log_result);
                    state_next = S_LKS;
                end
            end
            S_LKS:
            begin
                t_next     = (SUM_W'(total_reg) > sum_reg) ? (SUM_W'(total_reg) - sum_reg) : '0;
                state_next = S_LK;
            end
            S_LK:
            begin
                if (log_stat.done)
                begin
                    den_next   = PROD_W'(l_val) * PROD_W'(log_result);
                    state_next = S_NUM;
                end
            end
            S_NUM:
            begin
                // normalizer of zero scores zero
                res_next   = '0;
                state_next = (den_reg != '0) ? S_DIV : S_DONE;
            end
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    res_next   = (|div_quo[NUM_W-1:SCORE_W]) ? SCORE_MAX : div_quo[SCORE_W-1:0];
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    score_next      = res_reg;
                    passes_next     = (res_reg >= {thr_reg, 8'b0});
                    bases_seen_next = '0;
                    prev_next       = '0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLR;
            thr_reg        <= THR_RESET;
            bases_seen_reg <= '0;
            prev_reg       <= '0;
            idx_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            bases_seen_reg <= bases_seen_next;
            prev_reg       <= prev_next;
            idx_reg        <= idx_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
            begin
                thr_reg <= cfg_wdata;
            end
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        bin_reg    <= bin_next;
        last_reg   <= last_next;
        cnt_reg    <= cnt_next;
        prod_reg   <= prod_next;
        sum_reg    <= sum_next;
        total_reg  <= total_next;
        den_reg    <= den_next;
        t_reg      <= t_next;
        res_reg    <= res_next;
        score_reg  <= score_next;
        passes_reg <= passes_next;
    end

    assign out_valid = out_valid_reg;
    assign score     = score_reg;
    assign passes    = passes_reg;

    tes_hist_mem #(
        .DATA_W (CNT_W)
    ) u_hist (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    tes_log2 #(
        .CNT_W (CNT_W),
        .E_W   (E_W)
    ) u_log (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (log_start),
        .x      (log_x),
        .stat   (log_stat),
        .result (log_result)
    );

    tes_div #(
        .NUM_W (NUM_W),
        .DEN_W (PROD_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (den_reg),
        .stat  (div_stat),
        .quo   (div_quo)
    );

    // Checks
    `TES_ASSERT_NEXT(a_upd_follows_read, clk, rst_n, (acc && hist_upd), (state_reg == S_UPD))
    `TES_ASSERT_IMPL(a_log_start_idle, clk, rst_n, log_start, !log_stat.busy)
    `TES_ASSERT_IMPL(a_div_done_in_div, clk, rst_n, div_stat.done, (state_reg == S_DIV))

endmodule

[tb/sv/tes_score_checker.sv]
`timescale 1ns / 1ps
// Checker for the trinucleotide entropy score core: watches base and score transactions,
// computes the expected score and pass flag, and counts mismatches. Depends on tes_pkg.
module tes_score_checker
    import tes_pkg::*;
#(
    parameter int MAX_READ_LEN = DEF_MAX_READ_LEN,
    parameter int NORM_CAP     = DEF_NORM_CAP
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [THR_W-1:0]   cfg_wdata,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [BASE_W-1:0]  base,
    input  logic               last_base,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [SCORE_W-1:0] score,
    input  logic               passes,
    output int                 mismatches,
    output int                 pending_scores
);

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic               passes;
    } read_result_t;

    read_result_t      expected_scores[$];
    int unsigned       bin_counts[NUM_BINS];
    logic [5:0]        prev_pair;
    int unsigned       read_len;
    logic [THR_W-1:0]  threshold;

    // log2 in Q16 by repeated squaring of a Q30 mantissa
    function automatic longint unsigned log2_fixed(input int unsigned x);
        int unsigned     e;
        int unsigned     t;
        longint unsigned y;
        longint unsigned frac;
        e = 0;
        t = x;
        frac = 0;
        if (x == 0)
            return 0;
        while (t > 1)
        begin
            t = t >> 1;
            e++;
        end
        y = (longint'(x) << 30) >> e;
        for (int i = 0; i < 16; i++)
        begin
            y = (y * y) >> 30;
            frac = frac << 1;
            if (y >= (64'd2 << 30))
            begin
                frac = frac | 1;
                y = y >> 1;
            end
        end
        return (longint'(e) << 16) | frac;
    endfunction

    function automatic logic [SCORE_W-1:0] entropy_score();
        int unsigned     l;
        int unsigned     k;
        longint unsigned sum;
        longint unsigned total;
        longint unsigned t;
        longint unsigned den;
        longint unsigned q;
        sum = 0;
        if (read_len < 4)
            return '0;
        l = read_len - 2;
        k = (l < NORM_CAP) ? l : NORM_CAP;
        for (int i = 0; i < NUM_BINS; i++)
            if (bin_counts[i] != 0)
                sum += longint'(bin_counts[i]) * log2_fixed(bin_counts[i]);
        total = longint'(l) * log2_fixed(l);
        t = (total > sum) ? total - sum : 0;
        den = longint'(l) * log2_fixed(k);
        if (den == 0)
            return '0;
        q = (t * SCALE) / den;
        return (q > SCORE_MAX) ? SCORE_MAX : q[SCORE_W-1:0];
    endfunction

    function automatic void clear_read();
        foreach (bin_counts[i])
            bin_counts[i] = 0;
        prev_pair = '0;
        read_len = 0;
    endfunction

    assign pending_scores = expected_scores.size();

    always @(posedge clk or negedge rst_n)
    begin
        logic [2:0]   b;
        int unsigned  bin;
        read_result_t r;
        read_result_t got;
        if (!rst_n)
        begin
            clear_read();
            threshold = THR_RESET;
            expected_scores.delete();
            mismatches = 0;
        end
        else
        begin
            // base transaction: update histogram, predict on last base
            if (in_valid && !in_stall)
            begin
                b = (base > BASE_OTHER) ? BASE_OTHER : base;
                if (read_len < MAX_READ_LEN)
                begin
                    if (read_len >= 2)
                    begin
                        bin = (prev_pair[5:3] * 25 + prev_pair[2:0] * 5 + b) % NUM_BINS;
                        bin_counts[bin]++;
                    end
                    prev_pair = {prev_pair[2:0], b};
                    read_len++;
                end
                if (last_base)
                begin
                    r.score = entropy_score();
                    r.passes = (r.score >= {threshold, 8'd0});
                    expected_scores = {expected_scores, r};
                    clear_read();
                end
            end
            // score transaction
            if (out_valid && !out_stall)
            begin
                got.score = score;
                got.passes = passes;
                if (expected_scores.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected score transaction: score=%0d passes=%0b",
                                 score, passes);
                end
                else
                begin
                    r = expected_scores.pop_front();
                    if (got != r)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp score=%0d passes=%0b got score=%0d passes=%0b",
                                     r.score, r.passes, got.score, got.passes);
                    end
                end
            end
            if (cfg_we)
                threshold = cfg_wdata;
        end
    end

endmodule

[tb/sv/tb_trinucleotide_entropy_score_core.sv]
`timescale 1ns / 1ps
// Top of the trinucleotide entropy score testbench: clock, reset, read stimulus,
// threshold writes and verdict. Depends on tes_pkg, the core and tes_score_checker.
module tb_trinucleotide_entropy_score_core
    import tes_pkg::*;
();

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [THR_W-1:0]   cfg_wdata;
    logic               in_valid;
    logic               in_stall;
    logic [BASE_W-1:0]  base;
    logic               last_base;
    logic               out_valid;
    logic               out_stall;
    logic [SCORE_W-1:0] score;
    logic               passes;
    int                 mismatches;
    int                 pending_scores;
    int                 bases_sent;
    bit                 quiet_tail;
    bit                 hold_output;

    trinucleotide_entropy_score_core dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_stall(in_stall), .base(base), .last_base(last_base),
        .out_valid(out_valid), .out_stall(out_stall), .score(score), .passes(passes)
    );

    tes_score_checker checker_i (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_stall(in_stall), .base(base), .last_base(last_base),
        .out_valid(out_valid), .out_stall(out_stall), .score(score), .passes(passes),
        .mismatches(mismatches), .pending_scores(pending_scores)
    );

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #40ms;
        $display("FAIL");
        $finish;
    end

    // one base transaction, with an optional random gap before it
    task automatic send_base(input logic [BASE_W-1:0] b, input logic last);
        if (!quiet_tail && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_valid <= 1'b1;
        base <= b;
        last_base <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        bases_sent++;
    endtask

    task automatic send_read(input int len, input int mode);
        logic [BASE_W-1:0] b;
        for (int i = 0; i < len; i++)
        begin
            case (mode)
                0: b = 3'($urandom_range(0, 7));
                1: b = 3'($urandom_range(0, 3));
                2: b = 3'(i % 2);
                default: b = 3'($urandom_range(0, 1));
            endcase
            send_base(b, i == len - 1);
        end
    endtask

    task automatic settle_then_write(input logic [THR_W-1:0] v);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_scores != 0)
            @(posedge clk);
        repeat (10000) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // receiver: random stall bursts, one long hold-off on request
    initial
    begin
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_output)
            begin
                out_stall <= 1'b1;
                repeat (3000) @(posedge clk);
                out_stall <= 1'b0;
                hold_output = 0;
            end
            else if (!quiet_tail && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge clk);
                out_stall <= 1'b0;
            end
            @(posedge clk);
        end
    end

    initial
    begin
        int len;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        in_valid = 1'b0;
        base = '0;
        last_base = 1'b0;
        bases_sent = 0;
        quiet_tail = 0;
        hold_output = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: short reads, all codes, uniform and overlong reads
        send_base(3'd0, 1'b1);
        send_read(3, 1);
        send_read(4, 0);
        for (int c = 0; c < 8; c++)
            send_base(3'(c), c == 7);
        send_read(5, 2);
        settle_then_write(7'd0);
        send_read(300, 1);
        send_read(20, 3);
        settle_then_write(7'd127);
        send_read(100, 1);
        send_read(6, 2);
        settle_then_write(7'd100);

        // long output hold-off while reads keep coming
        hold_output = 1;
        for (int r = 0; r < 6; r++)
            send_read($urandom_range(4, 12), 1);

        // random reads, mostly short, with threshold changes between phases
        for (int ph = 0; ph < 4; ph++)
        begin
            while (bases_sent < 180 + ph * 230)
            begin
                len = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 270)
                                                   : $urandom_range(1, 24);
                send_read(len, $urandom_range(0, 3));
            end
            settle_then_write(7'($urandom_range(0, 127)));
        end
        quiet_tail = 1;
        while (bases_sent < 1100)
            send_read($urandom_range(1, 20), $urandom_range(0, 3));
        in_valid <= 1'b0;

        @(posedge clk);
        while (pending_scores != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
